>>> design/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Shared constants for the priority scheduler with aging: fixed field widths,
// command codes and result status codes.
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int ID_WIDTH     = 16;
    localparam int SLICE_WIDTH  = 16;
    localparam int STATUS_WIDTH = 2;
    localparam int CMD_WIDTH    = 1;

    // command codes
    localparam logic [CMD_WIDTH-1:0] CMD_ADD  = 1'b0;
    localparam logic [CMD_WIDTH-1:0] CMD_TICK = 1'b1;

    // result status codes
    localparam logic [STATUS_WIDTH-1:0] STAT_ADDED = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STAT_RAN   = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] STAT_IDLE  = 2'd3;

endpackage

>>> design/psa_ram.sv
// ----------------------------------------------------------------------------
// psa_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. Contents are not reset.
// ----------------------------------------------------------------------------
module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/priority_scheduler_with_aging_core.sv
// ----------------------------------------------------------------------------
// priority_scheduler_with_aging_core
// Task table kept in list order in a single RAM. An add appends a task; a
// tick stably sorts the table by descending priority, runs the front task one
// slice (dropping it if finished), doubles the others' priority (saturating).
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  in      | in  | in_valid/in_ready  | command, priority_req, service_time
//  out     | out | out_valid/out_ready| status, task_id, slice_index, finished
//
//  Add: result registered at the accept edge.
//  Tick: insertion sort (SORT_KEY, SORT_CMP, SORT_PUT), then RUN_FRONT loads
//  the result register and RUN_AGE ages the remaining tasks.
//  Reset clears the task count and the id counter; RAM contents are not cleared.
//  in_ready is high only in the idle state with the result register free or
//  draining; a stalled result holds in the output register.
// ----------------------------------------------------------------------------
module priority_scheduler_with_aging_core #(
    parameter int MAX_PROCS  = 16,
    parameter int PRIO_WIDTH = 16,
    parameter int TIME_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [psa_pkg::CMD_WIDTH-1:0]     command,
    input  logic [15:0]                       priority_req,
    input  logic [15:0]                       service_time,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [psa_pkg::STATUS_WIDTH-1:0]  status,
    output logic [psa_pkg::ID_WIDTH-1:0]      task_id,
    output logic [psa_pkg::SLICE_WIDTH-1:0]   slice_index,
    output logic                              finished
);

    import psa_pkg::*;

    localparam int AW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);

    typedef struct packed {
        logic [ID_WIDTH-1:0]   id;
        logic [PRIO_WIDTH-1:0] prio;
        logic [TIME_WIDTH-1:0] svc;
        logic [TIME_WIDTH-1:0] rt;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SORT_KEY  = 3'd1;
    localparam logic [2:0] ST_SORT_CMP  = 3'd2;
    localparam logic [2:0] ST_SORT_PUT  = 3'd3;
    localparam logic [2:0] ST_RUN_FRONT = 3'd4;
    localparam logic [2:0] ST_RUN_AGE   = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [ID_WIDTH-1:0]     next_id_reg, next_id_next;
    logic [AW-1:0]           i_reg, i_next;
    logic [AW-1:0]           j_reg, j_next;
    logic [AW-1:0]           k_reg, k_next;
    rec_t                    key_reg, key_next;
    logic                    fin_reg, fin_next;

    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_WIDTH-1:0] status_reg, status_next;
    logic [ID_WIDTH-1:0]     task_id_reg, task_id_next;
    logic [SLICE_WIDTH-1:0]  slice_reg, slice_next;
    logic                    finished_reg, finished_next;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    rec_t                    wr_rec;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [REC_W-1:0]        rd_data;
    rec_t                    rd_rec;
    logic                    fwd_hit_reg;
    rec_t                    fwd_rec_reg;

    logic                    in_acc;
    logic                    out_free;
    logic [AW-1:0]           last_idx;
    logic                    table_full;
    rec_t                    add_rec;
    rec_t                    front_rec;
    logic                    front_fin;
    rec_t                    aged_rec;

    psa_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_PROCS)
    ) u_task_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // write and read of the same entry in one cycle: take the written word
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
            fwd_rec_reg <= wr_rec;
        end
    end

    assign rd_rec     = fwd_hit_reg ? fwd_rec_reg : rec_t'(rd_data);
    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == ST_IDLE) && out_free;
    assign in_acc     = in_valid && in_ready;
    assign last_idx   = AW'(cnt_reg - CW'(1));
    assign table_full = (cnt_reg == CW'(MAX_PROCS));

    always_comb
    begin
        add_rec.id   = next_id_reg;
        add_rec.prio = PRIO_WIDTH'(priority_req);
        add_rec.svc  = TIME_WIDTH'(service_time);
        add_rec.rt   = '0;
    end

    // front task: one more slice, saturating
    always_comb
    begin
        front_rec = rd_rec;
        if (!(&rd_rec.rt))
        begin
            front_rec.rt = rd_rec.rt + TIME_WIDTH'(1);
        end
        front_fin = (front_rec.rt >= front_rec.svc);
    end

    // every other task: priority doubled, saturating
    always_comb
    begin
        aged_rec = rd_rec;
        if (rd_rec.prio[PRIO_WIDTH-1])
        begin
            aged_rec.prio = '1;
        end
        else
        begin
            aged_rec.prio = {rd_rec.prio[PRIO_WIDTH-2:0], 1'b0};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        next_id_next   = next_id_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        key_next       = key_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        task_id_next   = task_id_reg;
        slice_next     = slice_reg;
        finished_next  = finished_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_rec         = rd_rec;
        rd_en          = 1'b0;
        rd_addr        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    out_valid_next = 1'b1;
                    task_id_next   = '0;
                    slice_next     = '0;
                    finished_next  = 1'b0;
                    if (command == CMD_ADD)
                    begin
                        if (table_full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            status_next  = STAT_ADDED;
                            task_id_next = next_id_reg;
                            wr_en        = 1'b1;
                            wr_addr      = AW'(cnt_reg);
                            wr_rec       = add_rec;
                            cnt_next     = cnt_reg + CW'(1);
                            next_id_next = next_id_reg + ID_WIDTH'(1);
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        status_next = STAT_IDLE;
                    end
                    else
                    begin
                        // result is loaded later, when the front task is known
                        out_valid_next = 1'b0;
                        rd_en          = 1'b1;
                        if (cnt_reg == CW'(1))
                        begin
                            rd_addr    = '0;
                            state_next = ST_RUN_FRONT;
                        end
                        else
                        begin
                            rd_addr    = AW'(1);
                            i_next     = AW'(1);
                            state_next = ST_SORT_KEY;
                        end
                    end
                end
            end

            ST_SORT_KEY:
            begin
                key_next   = rd_rec;
                j_next     = i_reg;
                rd_en      = 1'b1;
                rd_addr    = i_reg - AW'(1);
                state_next = ST_SORT_CMP;
            end

            ST_SORT_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                if (rd_rec.prio < key_reg.prio)
                begin
                    // shift the lower-priority entry up one slot
                    wr_rec = rd_rec;
                    j_next = j_reg - AW'(1);
                    if (j_reg == AW'(1))
                    begin
                        state_next = ST_SORT_PUT;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = j_reg - AW'(2);
                    end
                end
                else
                begin
                    wr_rec = key_reg;
                    rd_en  = 1'b1;
                    if (i_reg == last_idx)
                    begin
                        rd_addr    = '0;
                        state_next = ST_RUN_FRONT;
                    end
                    else
                    begin
                        rd_addr    = i_reg + AW'(1);
                        i_next     = i_reg + AW'(1);
                        state_next = ST_SORT_KEY;
                    end
                end
            end

            ST_SORT_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_rec  = key_reg;
                rd_en   = 1'b1;
                if (i_reg == last_idx)
                begin
                    rd_addr    = '0;
                    state_next = ST_RUN_FRONT;
                end
                else
                begin
                    rd_addr    = i_reg + AW'(1);
                    i_next     = i_reg + AW'(1);
                    state_next = ST_SORT_KEY;
                end
            end

            ST_RUN_FRONT:
            begin
                out_valid_next = 1'b1;
                status_next    = STAT_RAN;
                task_id_next   = rd_rec.id;
                slice_next     = SLICE_WIDTH'(rd_rec.rt);
                finished_next  = front_fin;
                fin_next       = front_fin;
                wr_en          = !front_fin;
                wr_addr        = '0;
                wr_rec         = front_rec;
                if (cnt_reg == CW'(1))
                begin
                    cnt_next   = cnt_reg - CW'(front_fin);
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(1);
                    k_next     = AW'(1);
                    state_next = ST_RUN_AGE;
                end
            end

            ST_RUN_AGE:
            begin
                // a finished front task is dropped by moving the rest down
                wr_en   = 1'b1;
                wr_addr = fin_reg ? (k_reg - AW'(1)) : k_reg;
                wr_rec  = aged_rec;
                if (k_reg == last_idx)
                begin
                    cnt_next   = cnt_reg - CW'(fin_reg);
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = k_reg + AW'(1);
                    k_next  = k_reg + AW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        key_reg      <= key_next;
        fin_reg      <= fin_next;
        status_reg   <= status_next;
        task_id_reg  <= task_id_next;
        slice_reg    <= slice_next;
        finished_reg <= finished_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign task_id     = task_id_reg;
    assign slice_index = slice_reg;
    assign finished    = finished_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_PROCS))
        else $error("task count above table size");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && command == CMD_ADD && !table_full)
        |=> (cnt_reg == $past(cnt_reg) + CW'(1)) && out_valid && status == STAT_ADDED)
        else $error("accepted add did not append a task");

    a_empty_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && command == CMD_TICK && cnt_reg == '0)
        |=> out_valid && status == STAT_IDLE && state_reg == ST_IDLE)
        else $error("tick on empty table not reported idle");

    a_front_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN_FRONT) |=> out_valid && status == STAT_RAN)
        else $error("tick finished without a result");

    a_sort_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SORT_KEY || state_reg == ST_SORT_CMP || state_reg == ST_SORT_PUT)
        |-> !out_valid_reg)
        else $error("result pending while tick in progress");

endmodule

>>> dv/tb_priority_scheduler_with_aging_core.sv
// ----------------------------------------------------------------------------
// tb_priority_scheduler_with_aging_core
// Self-checking bench for the aging priority scheduler. A task-level
// predictor mirrors the task table (list order, stable sort, priority
// doubling, removal) and every result word is compared against it. Stimulus
// runs directed corners, biased random add/tick traffic, output back-pressure
// and long-service tasks, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_priority_scheduler_with_aging_core;
    import psa_pkg::*;

    localparam int NPROCS = 16;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0] status;
        logic [ID_WIDTH-1:0]     task_id;
        logic [SLICE_WIDTH-1:0]  slice_index;
        logic                    finished;
    } sched_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [CMD_WIDTH-1:0]          command;
    logic [15:0]                   priority_req;
    logic [15:0]                   service_time;
    logic                          out_valid;
    logic                          out_ready;
    logic [STATUS_WIDTH-1:0]       status;
    logic [ID_WIDTH-1:0]           task_id;
    logic [SLICE_WIDTH-1:0]        slice_index;
    logic                          finished;

    // predicted task table, slots 0..tbl_count-1 in list order
    logic [15:0] tbl_id   [NPROCS];
    logic [15:0] tbl_prio [NPROCS];
    logic [15:0] tbl_svc  [NPROCS];
    logic [15:0] tbl_run  [NPROCS];
    int          tbl_count = 0;
    logic [15:0] id_next   = '0;

    sched_result_t pending_results[$];
    int            fail_count = 0;
    bit            tx_calm;
    bit            rx_calm;
    int            rx_hold;

    priority_scheduler_with_aging_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .priority_req (priority_req),
        .service_time (service_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .task_id      (task_id),
        .slice_index  (slice_index),
        .finished     (finished)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Applies one word to the predicted table and returns the result it causes.
    function automatic sched_result_t schedule_outcome(logic [CMD_WIDTH-1:0] cmd,
                                                       logic [15:0] prio,
                                                       logic [15:0] svc);
        sched_result_t r;
        int          i;
        int          j;
        logic [15:0] k_id;
        logic [15:0] k_prio;
        logic [15:0] k_svc;
        logic [15:0] k_run;
        logic [16:0] dbl;
        r = '0;
        if (cmd == CMD_ADD)
        begin
            if (tbl_count == NPROCS)
                r.status = STAT_FULL;
            else
            begin
                tbl_id[tbl_count]   = id_next;
                tbl_prio[tbl_count] = prio;
                tbl_svc[tbl_count]  = svc;
                tbl_run[tbl_count]  = '0;
                tbl_count++;
                r.status  = STAT_ADDED;
                r.task_id = id_next;
                id_next   = id_next + 16'd1;
            end
        end
        else if (tbl_count == 0)
            r.status = STAT_IDLE;
        else
        begin
            // stable insertion sort, descending priority
            for (i = 1; i < tbl_count; i++)
            begin
                k_id   = tbl_id[i];
                k_prio = tbl_prio[i];
                k_svc  = tbl_svc[i];
                k_run  = tbl_run[i];
                j = i;
                while (j > 0 && tbl_prio[j-1] < k_prio)
                begin
                    tbl_id[j]   = tbl_id[j-1];
                    tbl_prio[j] = tbl_prio[j-1];
                    tbl_svc[j]  = tbl_svc[j-1];
                    tbl_run[j]  = tbl_run[j-1];
                    j--;
                end
                tbl_id[j]   = k_id;
                tbl_prio[j] = k_prio;
                tbl_svc[j]  = k_svc;
                tbl_run[j]  = k_run;
            end
            r.status      = STAT_RAN;
            r.task_id     = tbl_id[0];
            r.slice_index = tbl_run[0];
            if (tbl_run[0] != 16'hFFFF)
                tbl_run[0] = tbl_run[0] + 16'd1;
            for (i = 1; i < tbl_count; i++)
            begin
                dbl = {tbl_prio[i], 1'b0};
                tbl_prio[i] = dbl[16] ? 16'hFFFF : dbl[15:0];
            end
            if (tbl_run[0] >= tbl_svc[0])
            begin
                for (i = 1; i < tbl_count; i++)
                begin
                    tbl_id[i-1]   = tbl_id[i];
                    tbl_prio[i-1] = tbl_prio[i];
                    tbl_svc[i-1]  = tbl_svc[i];
                    tbl_run[i-1]  = tbl_run[i];
                end
                tbl_count--;
                r.finished = 1'b1;
            end
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with in_valid still high, so the caller either sends again or lowers it.
    task automatic send_word(logic [CMD_WIDTH-1:0] cmd, logic [15:0] prio,
                             logic [15:0] svc);
        while (!tx_calm && $urandom_range(0, 99) < 37)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        priority_req <= prio;
        service_time <= svc;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(schedule_outcome(cmd, prio, svc));
        @(negedge clk);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [15:0] pick_prio();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 15));
            2: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h8000;
            default: return ($urandom_range(0, 1) != 0) ? 16'h0100 : 16'h0003;
        endcase
    endfunction

    function automatic logic [15:0] pick_svc();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom_range(0, 63));
        return 16'($urandom_range(0, 7));
    endfunction

    task automatic test_directed();
        send_word(CMD_TICK, 16'hFFFF, 16'hFFFF);   // empty table reports idle
        send_word(CMD_ADD, 16'h0000, 16'h0000);
        send_word(CMD_ADD, 16'hFFFF, 16'h0001);
        send_word(CMD_ADD, 16'h8000, 16'h0002);
        send_word(CMD_ADD, 16'h7FFF, 16'h0000);
        for (int i = 0; i < 5; i++)
            send_word(CMD_ADD, 16'h0100, 16'(i));    // equal priorities
        for (int i = 0; i < 7; i++)
            send_word(CMD_ADD, 16'($urandom), 16'($urandom_range(0, 3)));
        send_word(CMD_ADD, 16'h1234, 16'h0005);    // table full
        for (int i = 0; i < 6; i++)
            send_word(CMD_TICK, 16'($urandom), 16'($urandom));
    endtask

    task automatic test_random();
        int add_pct;
        for (int blk = 0; blk < 17; blk++)
        begin
            add_pct = $urandom_range(20, 80);
            tx_calm = (blk >= 6 && blk <= 8);
            rx_calm = tx_calm;
            for (int i = 0; i < 50; i++)
            begin
                if ($urandom_range(0, 99) < add_pct)
                    send_word(CMD_ADD, pick_prio(), pick_svc());
                else
                    send_word(CMD_TICK, 16'($urandom), 16'($urandom));
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // Output held off while the sender keeps offering, then a full drain.
    task automatic test_backpressure();
        wait_results();
        rx_hold = 400;
        tx_calm = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            if (i % 3 == 2)
                send_word(CMD_TICK, 16'($urandom), 16'($urandom));
            else
                send_word(CMD_ADD, pick_prio(), pick_svc());
        end
        tx_calm = 1'b0;
        wait_results();
    endtask

    // Long service times last: these tasks never leave the table.
    task automatic test_long_tasks();
        logic [15:0] svc;
        for (int k = 0; k < 27; k++)
        begin
            if (k % 3 == 2)
                send_word(CMD_TICK, 16'($urandom), 16'($urandom));
            else
            begin
                case (k % 4)
                    0: svc = 16'hFFFF;
                    1: svc = 16'h8000;
                    default: svc = 16'($urandom) | 16'h8000;
                endcase
                send_word(CMD_ADD, pick_prio(), svc);
            end
        end
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                rx_hold--;
            end
            else
                out_ready <= rx_calm || ($urandom_range(0, 99) >= 37);
        end
    end

    task automatic note_mismatch(string field, int want, int got);
        fail_count++;
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        sched_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $error("result word with nothing pending");
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    note_mismatch("status", want.status, status);
                if (task_id !== want.task_id)
                    note_mismatch("task_id", want.task_id, task_id);
                if (slice_index !== want.slice_index)
                    note_mismatch("slice_index", want.slice_index, slice_index);
                if (finished !== want.finished)
                    note_mismatch("finished", want.finished, finished);
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_ADD;
        priority_req = '0;
        service_time = '0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        rx_hold      = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        test_backpressure();
        test_long_tasks();
        wait_results();
        repeat (400) @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> priority_scheduler_with_aging_core.f
design/psa_pkg.sv
design/psa_ram.sv
design/priority_scheduler_with_aging_core.sv
dv/tb_priority_scheduler_with_aging_core.sv
